FILE: rtl/calibrated_note_to_cv_top_macros.svh
// Assertion macros for the note to control-voltage converter.
`ifndef CALIBRATED_NOTE_TO_CV_TOP_MACROS_SVH
`define CALIBRATED_NOTE_TO_CV_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define CNTCV_ASSERT_HOLD(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define CNTCV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/cntcv_pkg.sv
// Shared types, constants and helper functions of the note to control-voltage converter.
`default_nettype none

package cntcv_pkg;

  localparam int VoiceCount  = 4;
  localparam int OctaveCount = 10;
  localparam int Points      = OctaveCount + 1;
  localparam int Semitones   = 12;
  localparam int BendSemis   = 2;
  localparam int BendCentre  = 8192;
  localparam int BendShift   = 13;
  localparam int FullScale   = 4095;
  localparam int NoteTop     = OctaveCount * Semitones;
  localparam int PerOct      = FullScale / OctaveCount;
  localparam int BendMax     = FullScale / NoteTop * BendSemis;
  localparam int CalDepth    = VoiceCount * Points;
  localparam int CalAw       = $clog2(CalDepth);
  localparam int CalW        = 7;
  localparam int CodeW       = 12;
  localparam int SegW        = 4;
  localparam int RawShift    = 3;
  localparam int RawMul      = FullScale * (1 << RawShift) / NoteTop;
  localparam int RecipShift  = 27;
  localparam int RecipMul    = ((1 << RecipShift) + PerOct - 1) / PerOct;
  localparam int ProdW       = 18;
  localparam int MulAW       = ProdW;
  localparam int MulBW       = $clog2(RecipMul + 1);
  localparam int MulPW       = MulAW + MulBW;

  typedef enum logic [1:0] {
    OpConvert   = 2'd0,
    OpBend      = 2'd1,
    OpCalibrate = 2'd2
  } opcode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_LO,
    ST_RD_HI,
    ST_MULT,
    ST_DIV_SCALE,
    ST_FINISH
  } state_e;

  function automatic logic [SegW-1:0] note_octave(input logic [6:0] n);
    logic [SegW-1:0] seg;
    seg = '0;
    for (int k = 1; k < OctaveCount; k++) begin
      if (n >= 7'(k * Semitones)) begin
        seg = seg + SegW'(1);
      end
    end
    return seg;
  endfunction

  function automatic logic [CalAw-1:0] cal_addr(input logic [1:0] voice,
                                                 input logic [SegW-1:0] point);
    return CalAw'(voice) * CalAw'(Points) + CalAw'(point);
  endfunction

endpackage

`default_nettype wire

FILE: rtl/cntcv_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module cntcv_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

FILE: rtl/calibrated_note_to_cv_top.sv
// Top level of the calibrated MIDI note to control-voltage DAC code converter.
//
// A convert beat steps through the table read, multiply and divide states to
// its result, and the input is ready again in the cycle that the result is
// raised. One shared multiplier does the conversion scaling: the note times
// 273/8 at acceptance, then, after two calibration table reads, the segment
// product, and last a reciprocal multiply that divides it by the 409-code
// octave width. The input is not ready while a conversion is in flight, nor
// while a finished result waits on a full output register. Bend and calibrate
// beats keep the input ready. The calibration table clears at reset through
// per-entry valid bits, with no clearing pass.
`default_nettype none
`include "calibrated_note_to_cv_top_macros.svh"

module calibrated_note_to_cv_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  opcode_i,
  input  wire logic [6:0]  note_i,
  input  wire logic [1:0]  voice_i,
  input  wire logic [13:0] bend_i,
  input  wire logic [3:0]  cal_point_i,
  input  wire logic signed [6:0] cal_offset_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [11:0]      cv_code_o
);

  cntcv_pkg::state_e state_q, state_d;

  logic                                 in_acc;
  logic                                 out_free;
  logic [6:0]                           ncap;
  logic [cntcv_pkg::SegW-1:0]           seg_q;
  logic [1:0]                           voice_q;
  logic [cntcv_pkg::CodeW-1:0]          lo_q;
  logic signed [7:0]                    bend_q;
  logic signed [cntcv_pkg::CalW-1:0]    c0_q;
  logic [cntcv_pkg::CalDepth-1:0]       vld_q;
  logic                                 rd_vld_q;
  logic [cntcv_pkg::CalAw-1:0]          rd_addr;
  logic [cntcv_pkg::CalAw-1:0]          wr_addr;
  logic                                 wr_en;
  logic signed [cntcv_pkg::CalW-1:0]    rd_data;
  logic signed [cntcv_pkg::CalW-1:0]    cal_rd;

  logic [cntcv_pkg::ProdW-1:0]          dq_q;
  logic [cntcv_pkg::MulAW-1:0]          mul_a;
  logic [cntcv_pkg::MulBW-1:0]          mul_b;
  logic [cntcv_pkg::MulPW-1:0]          mul_p;

  logic [8:0]                           seg_diff;
  logic signed [10:0]                   span;

  logic signed [14:0]                   bend_ctr;
  logic signed [21:0]                   bend_scl;
  logic signed [21:0]                   bend_rnd;

  logic signed [13:0]                   cv_sum;
  logic [cntcv_pkg::CodeW-1:0]          cv_sat;
  logic                                 out_valid_q;
  logic [cntcv_pkg::CodeW-1:0]          cv_q;

  assign in_ready_o  = (state_q == cntcv_pkg::ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign cv_code_o   = cv_q;

  assign ncap = (note_i > 7'(cntcv_pkg::NoteTop)) ? 7'(cntcv_pkg::NoteTop) : note_i;

  // calibration table
  assign wr_en   = in_acc && (opcode_i == cntcv_pkg::OpCalibrate)
                   && (cal_point_i < 4'(cntcv_pkg::Points));
  assign wr_addr = cntcv_pkg::cal_addr(voice_i, cal_point_i);
  assign rd_addr = (state_q == cntcv_pkg::ST_RD_LO)
                   ? cntcv_pkg::cal_addr(voice_q, seg_q)
                   : cntcv_pkg::cal_addr(voice_q, seg_q + cntcv_pkg::SegW'(1));
  assign cal_rd  = rd_vld_q ? rd_data : '0;

  cntcv_ram #(
    .Width (cntcv_pkg::CalW),
    .Depth (cntcv_pkg::CalDepth)
  ) u_cal_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (cal_offset_i),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // segment remap operands
  assign seg_diff = 9'(dq_q[cntcv_pkg::CodeW-1:0] - lo_q);
  assign span     = 11'(cntcv_pkg::PerOct) + 11'(cal_rd) - 11'(c0_q);

  // shared multiplier
  always_comb begin
    mul_a = cntcv_pkg::MulAW'(ncap);
    mul_b = cntcv_pkg::MulBW'(cntcv_pkg::RawMul);
    unique case (state_q)
      cntcv_pkg::ST_MULT: begin
        mul_a = cntcv_pkg::MulAW'(seg_diff);
        mul_b = cntcv_pkg::MulBW'(span[9:0]);
      end
      cntcv_pkg::ST_DIV_SCALE: begin
        mul_a = dq_q;
        mul_b = cntcv_pkg::MulBW'(cntcv_pkg::RecipMul);
      end
      default: begin
      end
    endcase
  end

  assign mul_p = cntcv_pkg::MulPW'(mul_a) * cntcv_pkg::MulPW'(mul_b);

  // bend offset, truncated toward zero
  assign bend_ctr = $signed({1'b0, bend_i}) - 15'sd8192;
  assign bend_scl = 22'(bend_ctr) * 22'sd68;
  assign bend_rnd = bend_scl + ((bend_scl < 0) ? 22'sd8191 : 22'sd0);

  // final sum and saturation
  assign cv_sum = $signed({4'b0000, dq_q[9:0]}) + $signed({2'b00, lo_q})
                  + 14'(c0_q) + 14'(bend_q);
  always_comb begin
    priority if (cv_sum < 0) begin
      cv_sat = '0;
    end else if (cv_sum > 14'sd4095) begin
      cv_sat = 12'(cntcv_pkg::FullScale);
    end else begin
      cv_sat = cv_sum[11:0];
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      cntcv_pkg::ST_IDLE: begin
        if (in_acc && (opcode_i == cntcv_pkg::OpConvert)) begin
          state_d = cntcv_pkg::ST_RD_LO;
        end
      end
      cntcv_pkg::ST_RD_LO:     state_d = cntcv_pkg::ST_RD_HI;
      cntcv_pkg::ST_RD_HI:     state_d = cntcv_pkg::ST_MULT;
      cntcv_pkg::ST_MULT:      state_d = cntcv_pkg::ST_DIV_SCALE;
      cntcv_pkg::ST_DIV_SCALE: state_d = cntcv_pkg::ST_FINISH;
      cntcv_pkg::ST_FINISH: begin
        if (out_free) begin
          state_d = cntcv_pkg::ST_IDLE;
        end
      end
      default: state_d = cntcv_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cntcv_pkg::ST_IDLE;
      vld_q       <= '0;
      bend_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (wr_en) begin
        vld_q[wr_addr] <= 1'b1;
      end
      if (in_acc && (opcode_i == cntcv_pkg::OpBend)) begin
        bend_q <= 8'(bend_rnd >>> cntcv_pkg::BendShift);
      end
      if ((state_q == cntcv_pkg::ST_FINISH) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_vld_q <= vld_q[rd_addr];
    unique case (state_q)
      cntcv_pkg::ST_IDLE: begin
        if (in_acc) begin
          voice_q <= voice_i;
          seg_q   <= cntcv_pkg::note_octave(ncap);
          lo_q    <= cntcv_pkg::CodeW'(cntcv_pkg::note_octave(ncap))
                     * cntcv_pkg::CodeW'(cntcv_pkg::PerOct);
          dq_q    <= cntcv_pkg::ProdW'(mul_p[cntcv_pkg::MulPW-1:cntcv_pkg::RawShift]);
        end
      end
      cntcv_pkg::ST_RD_HI: begin
        c0_q <= cal_rd;
      end
      cntcv_pkg::ST_MULT: begin
        dq_q <= mul_p[cntcv_pkg::ProdW-1:0];
      end
      cntcv_pkg::ST_DIV_SCALE: begin
        dq_q <= cntcv_pkg::ProdW'(mul_p[cntcv_pkg::MulPW-1:cntcv_pkg::RecipShift]);
      end
      cntcv_pkg::ST_FINISH: begin
        if (out_free) begin
          cv_q <= cv_sat;
        end
      end
      default: begin
      end
    endcase
  end

  `CNTCV_ASSERT_NEXT(a_convert_busy,
      in_acc && (opcode_i == cntcv_pkg::OpConvert), !in_ready_o,
      "convert beat accepted but input still ready")
  `CNTCV_ASSERT_HOLD(a_raw_in_segment, state_q == cntcv_pkg::ST_MULT,
      (dq_q[cntcv_pkg::CodeW-1:0] >= lo_q) && (dq_q[cntcv_pkg::ProdW-1:cntcv_pkg::CodeW] == '0),
      "scaled note below its octave segment")
  `CNTCV_ASSERT_HOLD(a_quot_bound, state_q == cntcv_pkg::ST_FINISH,
      dq_q[cntcv_pkg::ProdW-1:10] == '0, "segment quotient out of range")
  `CNTCV_ASSERT_NEXT(a_out_hold, out_valid_q && !out_ready_i,
      out_valid_q && $stable(cv_q), "result beat dropped or changed while stalled")

endmodule

`default_nettype wire
